// File: rtl/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefix deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int CMD_W             = 2;
    localparam int BYTE_W            = 8;
    localparam int STATUS_W          = 4;
    localparam int MAX_LENGTH_W      = 17;
    localparam int MAX_LENGTH_RESET  = 65536;
    localparam int MAX_FRAME_DEFAULT = 65536;
    localparam int HEADER_BYTES      = 4;
    localparam int HEADER_COUNT_W    = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_DATA   = 2'd0,
        CMD_TAKE   = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PAYLOAD  = 4'd0,
        ST_HEADER   = 4'd1,
        ST_REFUSED  = 4'd2,
        ST_BADLEN   = 4'd3,
        ST_BADSTATE = 4'd4,
        ST_PENDING  = 4'd5,
        ST_TAKEOK   = 4'd6,
        ST_FINISHOK = 4'd7,
        ST_TRUNC    = 4'd8
    } status_t;

endpackage

// File: rtl/lpd_in_if.sv
// ----------------------------------------------------------------------------
// lpd_in_if
// Input channel of the deframer: command and stream byte.
// ----------------------------------------------------------------------------
interface lpd_in_if;
    import lpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);

endinterface

// File: rtl/lpd_out_if.sv
// ----------------------------------------------------------------------------
// lpd_out_if
// Result channel of the deframer: status, payload byte and last marker.
// ----------------------------------------------------------------------------
interface lpd_out_if;
    import lpd_pkg::*;

    logic              valid;
    logic              ready;
    status_t           status;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output status, output out_byte, output last,
                    input ready);
    modport sink   (input valid, input status, input out_byte, input last,
                    output ready);

endinterface

// File: rtl/length_prefix_deframer_core.sv
// ----------------------------------------------------------------------------
// length_prefix_deframer_core
// Deframes 4-byte little-endian length-prefixed frames from a byte stream.
// ----------------------------------------------------------------------------
// Takes one beat per clock and gives exactly one result beat for each. A beat
// is caught in an input register, decoded there against the frame state and
// written into the result register as soon as that register is free; the frame
// state is a handful of small counters and one header length compare, decoded
// combinationally. When the result side stalls, the input register holds its
// beat and stream.ready drops in the same cycle, so nothing is lost or
// repeated. Payload bytes are passed through unbuffered with last on the final
// byte of the frame. The length limit in force is the smaller of max_length
// and MAX_FRAME; it is folded into a limit register when cfg_wdata is written.
module length_prefix_deframer_core #(
    parameter int MAX_FRAME = lpd_pkg::MAX_FRAME_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lpd_pkg::MAX_LENGTH_W-1:0] cfg_wdata,
    lpd_in_if.sink                          stream,
    lpd_out_if.source                       result
);
    import lpd_pkg::*;

    // the limit can never exceed what the 17-bit register holds
    localparam int REG_MAX   = (1 << MAX_LENGTH_W) - 1;
    localparam int LIMIT_CAP = (MAX_FRAME < REG_MAX) ? MAX_FRAME : REG_MAX;
    localparam int LEN_W     = $clog2(LIMIT_CAP + 1);
    localparam int LIM_RESET = (MAX_FRAME < MAX_LENGTH_RESET) ? MAX_FRAME
                                                               : MAX_LENGTH_RESET;
    localparam int HDR_W     = 8 * HEADER_BYTES;
    localparam int LOW_W     = 8 * (HEADER_BYTES - 1);
    localparam int CMP_W     = 25;
    localparam logic [CMP_W-1:0] MAX_FRAME_V = CMP_W'(MAX_FRAME);

    // length limit, folded from the register write
    logic [LEN_W-1:0] limit_reg;

    // input stage
    logic              s1_valid_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic [BYTE_W-1:0] s1_byte_reg;

    // frame state
    logic [HEADER_COUNT_W-1:0] header_count_reg, header_count_next;
    logic [LOW_W-1:0]          header_low_reg, header_low_next;
    logic [LEN_W-1:0]          frame_length_reg, frame_length_next;
    logic [LEN_W-1:0]          payload_count_reg, payload_count_next;
    logic                      failed_reg, failed_next;
    logic                      ended_reg, ended_next;

    // result stage
    logic              res_valid_reg;
    status_t           res_status_reg, status_next;
    logic [BYTE_W-1:0] res_byte_reg, byte_next;
    logic              res_last_reg, last_next;

    logic              out_free;
    logic              s1_advance;
    logic              frame_done;
    logic [HDR_W-1:0]  hdr_len;
    logic              len_bad;
    logic [LEN_W-1:0]  payload_inc;

    // handshake: result register frees up or drains this cycle
    assign out_free     = !res_valid_reg || result.ready;
    assign s1_advance   = s1_valid_reg && out_free;
    assign stream.ready = !s1_valid_reg || out_free;

    assign result.valid    = res_valid_reg;
    assign result.status   = res_status_reg;
    assign result.out_byte = res_byte_reg;
    assign result.last     = res_last_reg;

    // frame fully received and waiting for a take
    assign frame_done = (header_count_reg == HEADER_COUNT_W'(HEADER_BYTES))
                        && (frame_length_reg != '0)
                        && (payload_count_reg == frame_length_reg);

    // full header length once the fourth byte arrives
    assign hdr_len = {s1_byte_reg, header_low_reg};
    assign len_bad = (hdr_len == '0)
                     || (|hdr_len[HDR_W-1:LEN_W])
                     || (hdr_len[LEN_W-1:0] > limit_reg);

    assign payload_inc = payload_count_reg + LEN_W'(1);

    // beat decode
    always_comb
    begin
        header_count_next  = header_count_reg;
        header_low_next    = header_low_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        failed_next        = failed_reg;
        ended_next         = ended_reg;
        status_next        = ST_BADSTATE;
        byte_next          = '0;
        last_next          = 1'b0;

        unique case (s1_cmd_reg)
            CMD_DATA:
            begin
                priority if (failed_reg || ended_reg)
                begin
                    status_next = ST_BADSTATE;
                end
                else if (frame_done)
                begin
                    status_next = ST_REFUSED;
                end
                else if (header_count_reg < HEADER_COUNT_W'(HEADER_BYTES - 1))
                begin
                    // low header bytes land in order
                    header_low_next[8 * header_count_reg[1:0] +: 8] = s1_byte_reg;
                    header_count_next = header_count_reg + HEADER_COUNT_W'(1);
                    status_next       = ST_HEADER;
                end
                else if (header_count_reg == HEADER_COUNT_W'(HEADER_BYTES - 1))
                begin
                    header_count_next = HEADER_COUNT_W'(HEADER_BYTES);
                    if (len_bad)
                    begin
                        failed_next = 1'b1;
                        status_next = ST_BADLEN;
                    end
                    else
                    begin
                        frame_length_next = hdr_len[LEN_W-1:0];
                        status_next       = ST_HEADER;
                    end
                end
                else
                begin
                    payload_count_next = payload_inc;
                    status_next        = ST_PAYLOAD;
                    byte_next          = s1_byte_reg;
                    last_next          = (payload_inc == frame_length_reg);
                end
            end
            CMD_TAKE:
            begin
                priority if (failed_reg)
                begin
                    status_next = ST_BADSTATE;
                end
                else if (!frame_done)
                begin
                    status_next = ST_PENDING;
                end
                else
                begin
                    // re-arm for the next frame
                    header_count_next  = '0;
                    header_low_next    = '0;
                    frame_length_next  = '0;
                    payload_count_next = '0;
                    status_next        = ST_TAKEOK;
                end
            end
            CMD_FINISH:
            begin
                priority if (failed_reg)
                begin
                    status_next = ST_BADSTATE;
                end
                else if ((header_count_reg != '0) && !frame_done)
                begin
                    // stream ended inside a frame
                    failed_next = 1'b1;
                    status_next = ST_TRUNC;
                end
                else
                begin
                    ended_next  = 1'b1;
                    status_next = ST_FINISHOK;
                end
            end
            default:
            begin
                status_next = ST_BADSTATE;
            end
        endcase
    end

    // limit register, min of written value and MAX_FRAME
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LEN_W'(LIM_RESET);
        end
        else if (cfg_we)
        begin
            if (CMP_W'(cfg_wdata) > MAX_FRAME_V)
            begin
                limit_reg <= LEN_W'(MAX_FRAME);
            end
            else
            begin
                limit_reg <= LEN_W'(cfg_wdata);
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            s1_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            s1_cmd_reg  <= stream.command;
            s1_byte_reg <= stream.data_byte;
        end
    end

    // frame state, updated as each beat moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg  <= '0;
            header_low_reg    <= '0;
            frame_length_reg  <= '0;
            payload_count_reg <= '0;
            failed_reg        <= 1'b0;
            ended_reg         <= 1'b0;
        end
        else if (s1_advance)
        begin
            header_count_reg  <= header_count_next;
            header_low_reg    <= header_low_next;
            frame_length_reg  <= frame_length_next;
            payload_count_reg <= payload_count_next;
            failed_reg        <= failed_next;
            ended_reg         <= ended_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            res_status_reg <= status_next;
            res_byte_reg   <= byte_next;
            res_last_reg   <= last_next;
        end
    end

    // checks
    a_header_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg <= HEADER_COUNT_W'(HEADER_BYTES))
        else $error("header count beyond header size");

    a_payload_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        payload_count_reg <= frame_length_reg)
        else $error("payload count passed frame length");

    a_length_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_length_reg != '0) |-> (header_count_reg == HEADER_COUNT_W'(HEADER_BYTES)))
        else $error("frame length set without full header");

    a_badlen_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && (status_next == ST_BADLEN || status_next == ST_TRUNC))
        |=> failed_reg)
        else $error("failure not recorded");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for length_prefix_deframer_core: streams length-prefixed
// frames with random content and noise under several length limits, predicts
// every result beat, and compares it field by field with the result channel.
// ----------------------------------------------------------------------------
module tb;
    import lpd_pkg::*;

    // frame size cap of the instance, same as the block's default
    localparam int FRAME_CAP = MAX_FRAME_DEFAULT;

    // command code outside the defined set, must be answered with bad state
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // idle chance in percent on either side
    localparam int IDLE_PCT = 8;

    // length of the one long receiver hold-off
    localparam int HOLD_CYCLES = 60;

    // cycles with work outstanding and no beat moving before giving up
    localparam int STALL_LIMIT = 2000;

    // beats of random stimulus in total, spread over the random phases
    localparam int RANDOM_BEATS = 1850;
    localparam int RANDOM_PHASES = 6;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data;
    } stream_beat_t;

    typedef struct {
        status_t           status;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } deframed_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [MAX_LENGTH_W-1:0] cfg_wdata;

    lpd_in_if  stream_if ();
    lpd_out_if result_if ();

    length_prefix_deframer_core #(
        .MAX_FRAME (FRAME_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stream    (stream_if),
        .result    (result_if)
    );

    always #4 clk = ~clk;

    // beats waiting to be offered, and results the block still owes
    stream_beat_t stream_q[$];
    deframed_t    deframed_q[$];

    // shadow of the block's frame state and its one register
    logic [MAX_LENGTH_W-1:0]   max_len = MAX_LENGTH_W'(MAX_LENGTH_RESET);
    logic [HEADER_COUNT_W-1:0] hdr_cnt = '0;
    logic [23:0]               hdr_low = '0;
    logic [MAX_LENGTH_W-1:0]   frame_len = '0;
    logic [MAX_LENGTH_W-1:0]   pay_cnt = '0;
    logic                      failed = 1'b0;
    logic                      ended = 1'b0;

    // bookkeeping
    int  errors = 0;
    int  pushed = 0;
    int  accepted = 0;
    int  checked = 0;
    int  frames = 0;
    int  tail_case = 0;
    bit  no_idle = 1'b0;
    bit  [8:0] seen_status = '0;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // limit in force: the smaller of the register and the instance cap
    function automatic int frame_limit();
        return (int'(max_len) > FRAME_CAP) ? FRAME_CAP : int'(max_len);
    endfunction

    function automatic bit frame_complete();
        return hdr_cnt == HEADER_BYTES && frame_len != 0 && pay_cnt == frame_len;
    endfunction

    // one step of the deframer: updates the shadow state, returns the result
    function automatic deframed_t deframe(input logic [CMD_W-1:0] cmd,
                                          input logic [BYTE_W-1:0] b);
        deframed_t   r;
        logic [31:0] len;
        r.status   = ST_BADSTATE;
        r.out_byte = '0;
        r.last     = 1'b0;
        case (cmd)
            CMD_DATA: begin
                if (failed || ended)
                    r.status = ST_BADSTATE;
                else if (frame_complete())
                    r.status = ST_REFUSED;
                else if (hdr_cnt < HEADER_BYTES - 1) begin
                    // first three header bytes, little-endian
                    hdr_low  = hdr_low | (24'(b) << (8 * hdr_cnt));
                    hdr_cnt  = hdr_cnt + 1'b1;
                    r.status = ST_HEADER;
                end
                else if (hdr_cnt == HEADER_BYTES - 1) begin
                    // top header byte closes the length and checks it
                    len     = {b, hdr_low};
                    hdr_cnt = HEADER_COUNT_W'(HEADER_BYTES);
                    if (len == 0 || len > frame_limit()) begin
                        failed   = 1'b1;
                        r.status = ST_BADLEN;
                    end
                    else begin
                        frame_len = len[MAX_LENGTH_W-1:0];
                        r.status  = ST_HEADER;
                    end
                end
                else begin
                    // payload passes straight through
                    pay_cnt    = pay_cnt + 1'b1;
                    r.status   = ST_PAYLOAD;
                    r.out_byte = b;
                    r.last     = (pay_cnt == frame_len);
                end
            end
            CMD_TAKE: begin
                if (failed)
                    r.status = ST_BADSTATE;
                else if (!frame_complete())
                    r.status = ST_PENDING;
                else begin
                    hdr_cnt   = '0;
                    hdr_low   = '0;
                    frame_len = '0;
                    pay_cnt   = '0;
                    r.status  = ST_TAKEOK;
                end
            end
            CMD_FINISH: begin
                if (failed)
                    r.status = ST_BADSTATE;
                else if (hdr_cnt != 0 && !frame_complete()) begin
                    // stream ends inside a frame
                    failed   = 1'b1;
                    r.status = ST_TRUNC;
                end
                else begin
                    ended    = 1'b1;
                    r.status = ST_FINISHOK;
                end
            end
            default: r.status = ST_BADSTATE;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_beat(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
        stream_beat_t beat;
        beat.cmd  = cmd;
        beat.data = b;
        stream_q.push_back(beat);
        pushed++;
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(255));
    endfunction

    // harmless noise inside a frame: early take or the unused command
    task automatic push_noise();
        push_beat($urandom_range(1) ? CMD_TAKE : CMD_UNUSED, rand_byte());
    endtask

    task automatic push_header(input logic [31:0] len);
        for (int i = 0; i < HEADER_BYTES; i++)
            push_beat(CMD_DATA, len[8*i +: 8]);
    endtask

    // one well-formed frame with random payload; noise never lands after the
    // last payload beat so the stream stays aligned on frame boundaries
    task automatic push_frame(input int len, input bit noisy, input bit take_it);
        logic [31:0] hdr;
        hdr = len;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            push_beat(CMD_DATA, hdr[8*i +: 8]);
            if (noisy && $urandom_range(9) == 0)
                push_noise();
        end
        for (int i = 0; i < len; i++) begin
            push_beat(CMD_DATA, rand_byte());
            if (noisy && i < len - 1 && $urandom_range(9) == 0)
                push_noise();
        end
        // bytes offered against a complete frame get refused
        if (noisy && $urandom_range(2) == 0)
            repeat ($urandom_range(1, 2)) push_beat(CMD_DATA, rand_byte());
        if (take_it)
            push_beat(CMD_TAKE, rand_byte());
        frames++;
    endtask

    // mostly short frames, now and then a longer one
    function automatic int pick_len();
        int lim;
        int r;
        lim = frame_limit();
        r   = $urandom_range(99);
        if (r < 85)
            return $urandom_range(1, (lim < 8) ? lim : 8);
        else if (r < 97)
            return $urandom_range(1, (lim < 64) ? lim : 64);
        return $urandom_range(1, (lim < 300) ? lim : 300);
    endfunction

    // every offered beat taken and every result back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (stream_q.size() != 0 || stream_if.valid || deframed_q.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [MAX_LENGTH_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        max_len   = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // beats that must all be answered with bad state once the stream is dead
    task automatic push_after_failure();
        push_beat(CMD_DATA, rand_byte());
        push_beat(CMD_TAKE, rand_byte());
        push_beat(CMD_FINISH, rand_byte());
        push_beat(CMD_UNUSED, rand_byte());
        push_beat(CMD_DATA, rand_byte());
    endtask

    // ------------------------------------------------------------------------
    // stream driver: offers queued beats, holds a beat until it is taken
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : stream_driver
        stream_beat_t beat;
        if (!rst_n) begin
            stream_if.valid <= 1'b0;
        end
        else begin
            // beat taken at this edge: predict its result now
            if (stream_if.valid && stream_if.ready) begin
                deframed_q.push_back(deframe(stream_if.command, stream_if.data_byte));
                accepted++;
            end
            // free to offer the next beat, or to idle
            if (!stream_if.valid || stream_if.ready) begin
                if (stream_q.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    beat = stream_q.pop_front();
                    stream_if.valid     <= 1'b1;
                    stream_if.command   <= beat.cmd;
                    stream_if.data_byte <= beat.data;
                end
                else begin
                    stream_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: checks every result beat against the oldest prediction
    // ------------------------------------------------------------------------
    int hold_left = 0;
    bit held_once = 1'b0;

    always @(posedge clk) begin : result_monitor
        deframed_t want;
        if (!rst_n) begin
            result_if.ready <= 1'b0;
        end
        else begin
            if (result_if.valid && result_if.ready) begin
                if (deframed_q.size() == 0) begin
                    $error("result beat with nothing outstanding: status %0d",
                           result_if.status);
                    errors++;
                end
                else begin
                    want = deframed_q.pop_front();
                    checked++;
                    if (result_if.status <= ST_TRUNC)
                        seen_status[result_if.status] = 1'b1;
                    if (result_if.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, result_if.status);
                        errors++;
                    end
                    if (result_if.out_byte !== want.out_byte) begin
                        $error("out_byte: expected 0x%02h, actual 0x%02h",
                               want.out_byte, result_if.out_byte);
                        errors++;
                    end
                    if (result_if.last !== want.last) begin
                        $error("last: expected %0b, actual %0b",
                               want.last, result_if.last);
                        errors++;
                    end
                end
            end
            // one long hold-off while the sender keeps offering, so the
            // block fills up and has to drop stream ready
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (!held_once && checked >= 400 && stream_q.size() > 20) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                result_if.ready <= 1'b0;
            end
            else begin
                result_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: no beat moving on either side while work is outstanding
    // ------------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge clk) begin : watchdog
        if (!rst_n || (stream_if.valid && stream_if.ready)
                   || (result_if.valid && result_if.ready)
                   || (stream_q.size() == 0 && !stream_if.valid && deframed_q.size() == 0))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : sequencer
        int phase_end;
        logic [MAX_LENGTH_W-1:0] phase_max [RANDOM_PHASES];
        int partial;
        int len;

        // known values on every input from time zero
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        stream_if.valid     = 1'b0;
        stream_if.command   = CMD_DATA;
        stream_if.data_byte = '0;
        result_if.ready     = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, register still at its reset value
        push_beat(CMD_UNUSED, 8'h00);       // unused command when idle
        push_beat(CMD_TAKE, 8'hFF);         // take with no frame: pending
        push_header(32'd1);
        push_beat(CMD_TAKE, 8'h00);         // take after header only: pending
        push_beat(CMD_DATA, 8'hFF);         // only payload beat, last set
        push_beat(CMD_DATA, 8'h00);         // frame complete: refused
        push_beat(CMD_TAKE, 8'h00);
        push_header(32'd2);
        push_beat(CMD_DATA, 8'h00);
        push_beat(CMD_TAKE, 8'h00);         // take mid-payload: pending
        push_beat(CMD_UNUSED, 8'hFF);       // unused command mid-frame
        push_beat(CMD_DATA, 8'hFF);
        push_beat(CMD_TAKE, 8'h00);
        frames += 2;
        wait_drained();

        // length exactly at a small limit
        write_max_length(MAX_LENGTH_W'(3));
        push_header(32'd3);
        push_beat(CMD_DATA, 8'hAA);
        push_beat(CMD_DATA, 8'h55);
        push_beat(CMD_DATA, 8'h80);
        push_beat(CMD_TAKE, 8'h00);
        frames++;
        wait_drained();

        // random phases over several limits, the extremes among them
        phase_max[0] = MAX_LENGTH_W'(1);
        phase_max[1] = MAX_LENGTH_W'(2);
        phase_max[2] = MAX_LENGTH_W'($urandom_range(3, 40));
        phase_max[3] = MAX_LENGTH_W'(MAX_LENGTH_RESET);
        phase_max[4] = '1;                  // above the instance cap
        phase_max[5] = MAX_LENGTH_W'($urandom_range(1, (1 << MAX_LENGTH_W) - 1));
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_max_length(phase_max[p]);
            // one phase runs with both sides always willing
            no_idle   = (p == 3);
            phase_end = pushed + RANDOM_BEATS / RANDOM_PHASES;
            while (pushed < phase_end)
                push_frame(pick_len(), $urandom_range(3) == 0, 1'b1);
            wait_drained();
        end
        no_idle = 1'b0;

        // the stream can end only once per reset: pick one way to end it
        tail_case = $urandom_range(7);
        case (tail_case)
            0: begin
                // finish when idle, repeated; then data and the unused command get bad state, take is pending
                push_beat(CMD_FINISH, rand_byte());
                push_beat(CMD_FINISH, rand_byte());
                push_beat(CMD_DATA, rand_byte());
                push_beat(CMD_TAKE, rand_byte());
                push_beat(CMD_UNUSED, rand_byte());
            end
            1: begin
                // finish on a complete frame, take still allowed afterwards
                push_frame(pick_len(), 1'b0, 1'b0);
                push_beat(CMD_FINISH, rand_byte());
                push_beat(CMD_DATA, rand_byte());
                push_beat(CMD_TAKE, rand_byte());
                push_beat(CMD_TAKE, rand_byte());
                push_beat(CMD_FINISH, rand_byte());
                push_beat(CMD_DATA, rand_byte());
            end
            2: begin
                // finish inside the header
                partial = $urandom_range(1, HEADER_BYTES - 1);
                for (int i = 0; i < partial; i++)
                    push_beat(CMD_DATA, 8'(1 + i));
                push_beat(CMD_FINISH, rand_byte());
                push_after_failure();
            end
            3: begin
                // finish inside the payload
                len = pick_len();
                push_header(len);
                repeat ($urandom_range(0, len - 1))
                    push_beat(CMD_DATA, rand_byte());
                push_beat(CMD_FINISH, rand_byte());
                push_after_failure();
            end
            4: begin
                // zero length header
                push_header(32'd0);
                push_after_failure();
            end
            5: begin
                // one above the limit, or the largest length a header holds
                push_header($urandom_range(1) ? 32'(frame_limit() + 1) : 32'hFFFF_FFFF);
                push_after_failure();
            end
            6: begin
                // zero register rejects every length
                write_max_length('0);
                push_header(32'($urandom_range(1, 8)));
                push_after_failure();
            end
            default: begin
                // register above the cap: the cap still applies
                write_max_length('1);
                push_header(32'(FRAME_CAP + 1));
                push_after_failure();
            end
        endcase
        wait_drained();
        repeat (8) @(posedge clk);

        $display("covered: %0d beats in, %0d results checked, %0d frames, end case %0d",
                 accepted, checked, frames, tail_case);
        $display("statuses seen (bit per code): %09b, long result hold-off: %0b",
                 seen_status, held_once);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
